@@ rtl/core/guide_offtarget_score_macros.svh @@
// Assertion macros shared by the guide off-target scoring RTL.
// Included by modules that carry concurrent checks; needs no other file.
`ifndef GUIDE_OFFTARGET_SCORE_MACROS_SVH
`define GUIDE_OFFTARGET_SCORE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define GOS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define GOS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/gos_pkg.sv @@
// Types and constants of the guide off-target scoring block.
// No dependencies; imported by guide_offtarget_score.
`default_nettype none

package gos_pkg;

   // Field widths fixed by the stream format
   localparam int NT_W        = 2;
   localparam int SEQ_W       = 40;
   localparam int START_W     = 32;
   localparam int REQ_DATA_W  = 72;
   localparam int RSP_DATA_W  = 96;
   localparam int RSP_USER_W  = 2;

   // Configuration port
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 40;
   localparam int WLEN_W      = 5;
   localparam int SW_W        = 9;

   // Datapath widths (bounded by the 40-bit sequence fields: at most 20 mismatches)
   localparam int K_W         = 5;
   localparam int D_W         = 10;
   localparam int W_W         = 18;
   localparam int WSUM_W      = 22;
   localparam int T_W         = 10;
   localparam int INNER_W     = 12;
   localparam int CORE_W      = 16;
   localparam int DEN_W       = 24;
   localparam int NUM_W       = 30;
   localparam int QB          = 13;
   localparam int DIV_CNT_W   = 4;
   localparam int SCORE_W     = 13;
   localparam int SUM_W       = 24;
   localparam int CNT_W       = 16;
   localparam int SPEC_W      = 24;
   localparam int GC_W        = 5;
   localparam int EFF_W       = 7;
   localparam int PEN_W       = 7;
   localparam int ACC_W       = 36;

   localparam logic [NT_W-1:0]    NT_C        = 2'd1;
   localparam logic [NT_W-1:0]    NT_G        = 2'd2;
   localparam logic [SCORE_W-1:0] SCORE_MAX   = 13'd6400;
   localparam logic [SUM_W-1:0]   SPEC_FULL   = 24'd25600;
   localparam logic [CNT_W-1:0]   CNT_MAX     = 16'hFFFF;
   localparam logic [SW_W-1:0]    SW_ONE      = 9'd256;
   localparam logic [PEN_W-1:0]   PEN_HIGH    = 7'd65;
   localparam logic [PEN_W-1:0]   PEN_MID     = 7'd35;
   localparam logic [PEN_W-1:0]   PEN_FIRST   = 7'd35;
   localparam logic [EFF_W-1:0]   EFF_BASE    = 7'd100;
   localparam logic signed [25:0] SPEC_BIAS   = 26'sd1792;
   localparam logic signed [SPEC_W-1:0] S24_MAX = 24'sh7FFFFF;
   localparam logic signed [SPEC_W-1:0] S24_MIN = 24'sh800000;

   // Per-position mismatch weights e^(1-M), Q16, for the last 20 positions
   localparam int WTAB_N  = 20;
   localparam int WTAB_IW = 5;
   localparam logic [W_W-1:0] WEIGHT_DEF = 18'd178145;
   localparam logic [W_W-1:0] WEIGHT_TAB [WTAB_N] = '{
      18'd178145, 18'd178145, 18'd175669, 18'd178145, 18'd178145,
      18'd120013, 18'd129749, 18'd178145, 18'd120735, 18'd164613,
      18'd114160, 18'd107190, 18'd96505,  18'd76066,  18'd85678,
      18'd77836,  18'd96313,  18'd79726,  18'd89801,  18'd99444
   };

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_GUIDE_SEQ  = 3'd0,
      CSR_WIN_LEN    = 3'd1,
      CSR_MAX_MM     = 3'd2,
      CSR_SPEC_W     = 3'd3,
      CSR_FINAL_MODE = 3'd4,
      CSR_GUIDE_POS  = 3'd5
   } csr_index_type;

   typedef enum logic [10:0] {
      S_IDLE = 11'b000_0000_0001,
      S_SCAN = 11'b000_0000_0010,
      S_MUL1 = 11'b000_0000_0100,
      S_MUL2 = 11'b000_0000_1000,
      S_PREP = 11'b000_0001_0000,
      S_CHK  = 11'b000_0010_0000,
      S_DIV  = 11'b000_0100_0000,
      S_ACC  = 11'b000_1000_0000,
      S_SPEC = 11'b001_0000_0000,
      S_PROD = 11'b010_0000_0000,
      S_DONE = 11'b100_0000_0000
   } state_type;

endpackage

`default_nettype wire

@@ rtl/core/guide_offtarget_score.sv @@
// Guide off-target mismatch scoring: top level with serial scan and divider.
// Depends on gos_pkg and guide_offtarget_score_macros.svh.
//
// Use: write the guide and the scoring registers on the csr_ port while the
// block is idle, then stream candidate sites on req_ (tlast marks the final
// site of the guide). Each site gives one item on rsp_: its score, mismatch
// count and flags, and on the final site the efficiency, specificity and
// weighted total (tlast set); the running sum and listed count then clear.
// The next site can be taken in the cycle after the result of the
// previous one is registered, not before. The scan compares one
// nucleotide position per cycle from the shift registers; a restoring
// divider then gives 13 quotient bits, one a cycle, followed by fixed
// accumulate, specificity and product steps.
// The result sits in an output register: if rsp_tready is low the block
// holds it, finishes the next site and waits until the register frees up.
// Synchronous reset returns the configuration registers to their defaults
// and clears the sum and listed count; no clearing pass is needed.
`default_nettype none
`include "guide_offtarget_score_macros.svh"

module guide_offtarget_score #(
   parameter int SEQ_LEN = 20
) (
   input  logic                              clock,
   input  logic                              reset,
   // configuration writes
   input  logic                              csr_we,
   input  logic [gos_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [gos_pkg::CSR_DATA_W-1:0]    csr_wdata,
   // candidate sites
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // req_tdata from bit 0: site_sequence[39:0], site_start[71:40]
   input  logic [gos_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic                              req_tlast,
   // site results
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // rsp_tdata from bit 0: site_score[12:0], mismatch_count[17:13],
   // gc_count[22:18], eff_score[29:23], spec_score[53:30],
   // total_score[77:54], listed_count[93:78], zero fill[95:94]
   output logic [gos_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // rsp_tuser from bit 0: site_listed[0], site_skipped[1]
   output logic [gos_pkg::RSP_USER_W-1:0]    rsp_tuser,
   output logic                              rsp_tlast
);
   import gos_pkg::*;

   localparam int SEQ_BITS  = 2 * SEQ_LEN;
   localparam int EXT_W     = (SEQ_BITS > SEQ_W) ? SEQ_BITS : SEQ_W;
   localparam int POS_W     = $clog2(SEQ_LEN);
   localparam int TAB_SHIFT = WTAB_N - SEQ_LEN;

   // configuration registers
   logic [SEQ_W-1:0]   guide_ff;
   logic [WLEN_W-1:0]  wlen_ff;
   logic [K_W-1:0]     maxmm_ff;
   logic [SW_W-1:0]    sw_ff;
   logic               mode_ff;
   logic [START_W-1:0] gpos_ff;

   // control and accumulated state
   state_type          state_ff, state_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [CNT_W-1:0]   listed_ff, listed_in;
   logic               rsp_valid_ff;

   // scan datapath
   logic [SEQ_BITS-1:0] gsr_ff, ssr_ff;
   logic [POS_W-1:0]    pos_ff;
   logic [WLEN_W-1:0]   off_ff;
   logic [K_W-1:0]      k_ff;
   logic [D_W-1:0]      d_ff;
   logic [WSUM_W-1:0]   wsum_ff;
   logic [GC_W-1:0]     gc_ff;
   logic                first_g_ff;
   logic                skip_ff;
   logic                last_ff;

   // multiply and divide datapath
   logic [NUM_W-1:0]    num_ff;
   logic [T_W-1:0]      t_ff;
   logic [CORE_W-1:0]   core_ff;
   logic [NUM_W-1:0]    n_ff;
   logic                ovf_ff;
   logic [DEN_W:0]      rem_ff;
   logic [QB-1:0]       nlo_ff;
   logic [QB-1:0]       q_ff;
   logic [DIV_CNT_W-1:0] div_cnt_ff;

   // final stage datapath
   logic [SCORE_W-1:0]  score_ff;
   logic                site_listed_ff;
   logic [PEN_W-1:0]    pen_ff;
   logic [SW_W-1:0]     w_ff;
   logic signed [SPEC_W-1:0] spec_ff;
   logic signed [ACC_W-1:0]  acc_ff;

   // output register
   logic [SCORE_W-1:0]  out_score_ff;
   logic [K_W-1:0]      out_k_ff;
   logic                out_listed_ff;
   logic                out_skip_ff;
   logic                out_last_ff;
   logic [GC_W-1:0]     out_gc_ff;
   logic [EFF_W-1:0]    out_eff_ff;
   logic [SPEC_W-1:0]   out_spec_ff;
   logic [SPEC_W-1:0]   out_total_ff;
   logic [CNT_W-1:0]    out_cnt_ff;

   // combinational helpers
   logic [WLEN_W-1:0]   len;
   logic [WLEN_W-1:0]   nm1;
   logic [EXT_W-1:0]    gext, sext;
   logic [NT_W-1:0]     g_nt, s_nt;
   logic                mm;
   logic [W_W-1:0]      wt;
   logic [WSUM_W+WLEN_W-1:0] prod1;
   logic [INNER_W-1:0]  inner;
   logic [K_W+INNER_W-1:0] prod2;
   logic [DEN_W-1:0]    den;
   logic [DEN_W:0]      trial;
   logic [SCORE_W-1:0]  score_c;
   logic                listed_c;
   logic [SUM_W:0]      sum_add;
   logic [8:0]          g10, l4, l5, l7, l8;
   logic [PEN_W-1:0]    pen_c;
   logic signed [25:0]  spec0;
   logic signed [SPEC_W-1:0] spec_c;
   logic signed [33:0]  p1;
   logic [15:0]         p2;
   logic signed [ACC_W-1:0] acc_in;
   logic signed [ACC_W-9:0] total_wide;
   logic signed [SPEC_W-1:0] total_c;
   logic                out_free;
   logic                done_fire;

   // effective window length, clamped to 2..SEQ_LEN
   always_comb begin
      if (wlen_ff < WLEN_W'(2)) begin
         len = WLEN_W'(2);
      end else if ({1'b0, wlen_ff} > 6'(SEQ_LEN)) begin
         len = WLEN_W'(SEQ_LEN);
      end else begin
         len = wlen_ff;
      end
   end
   assign nm1 = len - WLEN_W'(1);

   assign gext = EXT_W'(guide_ff);
   assign sext = EXT_W'(req_tdata[SEQ_W-1:0]);

   // compare the top nucleotide of both shift registers
   assign g_nt = gsr_ff[SEQ_BITS-1 -: NT_W];
   assign s_nt = ssr_ff[SEQ_BITS-1 -: NT_W];
   assign mm   = (g_nt != s_nt) && !skip_ff;

   // weight of the position under the scan
   always_comb begin
      int widx;
      widx = int'(pos_ff) + TAB_SHIFT;
      if (widx < 0 || widx >= WTAB_N) begin
         wt = WEIGHT_DEF;
      end else begin
         wt = WEIGHT_TAB[widx[WTAB_IW-1:0]];
      end
   end

   // numerator and denominator factors
   assign prod1 = wsum_ff * nm1;
   assign inner = INNER_W'({d_ff, 2'b00}) + INNER_W'(t_ff);
   assign prod2 = k_ff * inner;
   assign den   = {core_ff, 8'h00};
   assign trial = {rem_ff[DEN_W-1:0], nlo_ff[QB-1]};

   // site score and listing decision
   always_comb begin
      if (skip_ff) begin
         score_c = '0;
      end else if (k_ff == '0) begin
         score_c = SCORE_MAX;
      end else if (k_ff > maxmm_ff) begin
         score_c = '0;
      end else if (ovf_ff || q_ff > SCORE_MAX) begin
         score_c = SCORE_MAX;
      end else begin
         score_c = q_ff;
      end
   end
   assign listed_c = !skip_ff && mode_ff && (k_ff <= maxmm_ff);
   assign sum_add  = {1'b0, sum_ff} + (SUM_W+1)'(score_c);

   // GC-content and first-base penalty
   assign g10 = {1'b0, gc_ff, 3'b000} + {3'b000, gc_ff, 1'b0};
   assign l4  = {2'b00, len, 2'b00};
   assign l8  = {1'b0, len, 3'b000};
   assign l5  = l4 + 9'(len);
   assign l7  = l8 - 9'(len);
   always_comb begin
      if (g10 < l4 || g10 > l8) begin
         pen_c = PEN_HIGH;
      end else if (g10 > l5 && g10 < l7) begin
         pen_c = '0;
      end else begin
         pen_c = PEN_MID;
      end
      if (!first_g_ff) begin
         pen_c = pen_c + PEN_FIRST;
      end
   end

   // specificity in either mode
   assign spec0 = signed'(26'(sum_ff)) - signed'(26'({pen_ff, 8'h00})) + SPEC_BIAS;
   always_comb begin
      if (mode_ff) begin
         if (sum_ff > SPEC_FULL) begin
            spec_c = '0;
         end else begin
            spec_c = signed'(SPEC_FULL - sum_ff);
         end
      end else if (spec0 > 26'(S24_MAX)) begin
         spec_c = S24_MAX;
      end else if (spec0 < 26'(S24_MIN)) begin
         spec_c = S24_MIN;
      end else begin
         spec_c = spec0[SPEC_W-1:0];
      end
   end

   // weighted total, rounded half up, then saturated
   assign p1     = signed'({1'b0, w_ff}) * spec_ff;
   assign p2     = (SW_ONE - w_ff) * EFF_W'(EFF_BASE - pen_ff);
   assign acc_in = ACC_W'(p1) + signed'(ACC_W'({p2, 8'h80}));
   assign total_wide = acc_ff[ACC_W-1:8];
   always_comb begin
      if (total_wide > 28'(S24_MAX)) begin
         total_c = S24_MAX;
      end else if (total_wide < 28'(S24_MIN)) begin
         total_c = S24_MIN;
      end else begin
         total_c = total_wide[SPEC_W-1:0];
      end
   end

   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign done_fire = (state_ff == S_DONE) && out_free;

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (req_tvalid) state_in = S_SCAN;
         S_SCAN: if (off_ff == '0) state_in = S_MUL1;
         S_MUL1: state_in = S_MUL2;
         S_MUL2: state_in = S_PREP;
         S_PREP: state_in = S_CHK;
         S_CHK:  state_in = S_DIV;
         S_DIV:  if (div_cnt_ff == DIV_CNT_W'(QB - 1)) state_in = S_ACC;
         S_ACC:  state_in = S_SPEC;
         S_SPEC: state_in = S_PROD;
         S_PROD: state_in = S_DONE;
         S_DONE: if (out_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // running sum and listed count: add in the accumulate step, clear after
   // the final site
   always_comb begin
      sum_in    = sum_ff;
      listed_in = listed_ff;
      if (state_ff == S_ACC) begin
         sum_in = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
         if (listed_c && listed_ff != CNT_MAX) begin
            listed_in = listed_ff + CNT_W'(1);
         end
      end else if (done_fire && last_ff) begin
         sum_in    = '0;
         listed_in = '0;
      end
   end

   assign req_tready = (state_ff == S_IDLE);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sum_ff       <= '0;
         listed_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         guide_ff     <= '0;
         wlen_ff      <= WLEN_W'(20);
         maxmm_ff     <= K_W'(4);
         sw_ff        <= SW_W'(128);
         mode_ff      <= 1'b1;
         gpos_ff      <= '0;
      end else begin
         state_ff  <= state_in;
         sum_ff    <= sum_in;
         listed_ff <= listed_in;
         if (done_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_we) begin
            case (csr_addr)
               CSR_GUIDE_SEQ:  guide_ff <= csr_wdata[SEQ_W-1:0];
               CSR_WIN_LEN:    wlen_ff  <= csr_wdata[WLEN_W-1:0];
               CSR_MAX_MM:     maxmm_ff <= csr_wdata[K_W-1:0];
               CSR_SPEC_W:     sw_ff    <= csr_wdata[SW_W-1:0];
               CSR_FINAL_MODE: mode_ff  <= csr_wdata[0];
               CSR_GUIDE_POS:  gpos_ff  <= csr_wdata[START_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            // load the window, top position first
            gsr_ff  <= gext[SEQ_BITS-1:0];
            ssr_ff  <= sext[SEQ_BITS-1:0];
            pos_ff  <= POS_W'(SEQ_LEN - 1);
            off_ff  <= nm1;
            k_ff    <= '0;
            d_ff    <= '0;
            wsum_ff <= '0;
            gc_ff   <= '0;
            skip_ff <= (req_tdata[REQ_DATA_W-1:SEQ_W] == gpos_ff);
            last_ff <= req_tlast;
         end
         S_SCAN: begin
            // advance one nucleotide position
            gsr_ff <= gsr_ff << NT_W;
            ssr_ff <= ssr_ff << NT_W;
            pos_ff <= pos_ff - POS_W'(1);
            off_ff <= off_ff - WLEN_W'(1);
            if (mm) begin
               k_ff    <= k_ff + K_W'(1);
               d_ff    <= d_ff + D_W'(off_ff);
               wsum_ff <= wsum_ff + WSUM_W'(wt);
            end
            if (g_nt == NT_C || g_nt == NT_G) begin
               gc_ff <= gc_ff + GC_W'(1);
            end
            first_g_ff <= (g_nt == NT_G);
         end
         S_MUL1: begin
            num_ff <= NUM_W'({prod1, 2'b00});
            t_ff   <= T_W'(nm1) * T_W'(k_ff);
         end
         S_MUL2: begin
            core_ff <= prod2[CORE_W-1:0];
         end
         S_PREP: begin
            // add half the divisor for rounding
            n_ff <= num_ff + NUM_W'({core_ff, 7'b000_0000});
         end
         S_CHK: begin
            // quotient of 2^13 or more saturates anyway
            ovf_ff     <= DEN_W'(n_ff[NUM_W-1:QB]) >= den;
            rem_ff     <= (DEN_W+1)'(n_ff[NUM_W-1:QB]);
            nlo_ff     <= n_ff[QB-1:0];
            q_ff       <= '0;
            div_cnt_ff <= '0;
         end
         S_DIV: begin
            // one restoring step per cycle
            if (trial >= {1'b0, den}) begin
               rem_ff <= trial - {1'b0, den};
               q_ff   <= {q_ff[QB-2:0], 1'b1};
            end else begin
               rem_ff <= trial;
               q_ff   <= {q_ff[QB-2:0], 1'b0};
            end
            nlo_ff     <= nlo_ff << 1;
            div_cnt_ff <= div_cnt_ff + DIV_CNT_W'(1);
         end
         S_ACC: begin
            score_ff       <= score_c;
            site_listed_ff <= listed_c;
            pen_ff         <= pen_c;
            w_ff           <= (sw_ff > SW_ONE) ? SW_ONE : sw_ff;
         end
         S_SPEC: begin
            spec_ff <= spec_c;
         end
         S_PROD: begin
            acc_ff <= acc_in;
         end
         S_DONE: begin
            if (out_free) begin
               out_score_ff  <= score_ff;
               out_k_ff      <= skip_ff ? '0 : k_ff;
               out_listed_ff <= site_listed_ff;
               out_skip_ff   <= skip_ff;
               out_last_ff   <= last_ff;
               out_gc_ff     <= last_ff ? gc_ff : '0;
               out_eff_ff    <= last_ff ? EFF_W'(EFF_BASE - pen_ff) : '0;
               out_spec_ff   <= last_ff ? spec_ff : '0;
               out_total_ff  <= last_ff ? total_c : '0;
               out_cnt_ff    <= listed_ff;
            end
         end
         default: ;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, out_cnt_ff, out_total_ff, out_spec_ff, out_eff_ff,
                        out_gc_ff, out_k_ff, out_score_ff};
   assign rsp_tuser  = {out_skip_ff, out_listed_ff};
   assign rsp_tlast  = out_last_ff;

   // checks
   `GOS_ASSERT_NEXT(a_accept_scan, clock, reset, req_tvalid && req_tready,
      state_ff == S_SCAN, "accepted item did not start the scan")
   `GOS_ASSERT_SAME(a_score_max, clock, reset, rsp_valid_ff,
      out_score_ff <= SCORE_MAX, "site score above its maximum")
   `GOS_ASSERT_SAME(a_skip_quiet, clock, reset, rsp_valid_ff && out_skip_ff,
      out_score_ff == '0 && !out_listed_ff && out_k_ff == '0,
      "skipped site carries a score")
   `GOS_ASSERT_NEXT(a_cnt_hold, clock, reset, state_ff != S_ACC && state_ff != S_DONE,
      $stable(listed_ff), "listed count moved outside accumulate or finish")
   `GOS_ASSERT_SAME(a_div_count, clock, reset, state_ff == S_DIV,
      div_cnt_ff < DIV_CNT_W'(QB), "divider ran past its last step")

endmodule

`default_nettype wire
